>>> src/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg: shared types and constants for the planar odometry integrator
// Holds register indexes, the rotation table and the queue entry type.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_USE_MIDPOINT  = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } cfg_reg_e;

  localparam logic signed [63:0] TurnScale  = 64'sd683565276;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;
  localparam int unsigned        MaxIter    = 24;

  function automatic logic signed [35:0] atan_turn(input logic [4:0] idx);
    logic signed [35:0] r;
    case (idx)
      5'd0:  r = 36'sd536870912;
      5'd1:  r = 36'sd316933406;
      5'd2:  r = 36'sd167458907;
      5'd3:  r = 36'sd85004756;
      5'd4:  r = 36'sd42667331;
      5'd5:  r = 36'sd21354465;
      5'd6:  r = 36'sd10679838;
      5'd7:  r = 36'sd5340245;
      5'd8:  r = 36'sd2670163;
      5'd9:  r = 36'sd1335087;
      5'd10: r = 36'sd667544;
      5'd11: r = 36'sd333772;
      5'd12: r = 36'sd166886;
      5'd13: r = 36'sd83443;
      5'd14: r = 36'sd41722;
      5'd15: r = 36'sd20861;
      5'd16: r = 36'sd10430;
      5'd17: r = 36'sd5215;
      5'd18: r = 36'sd2608;
      5'd19: r = 36'sd1304;
      5'd20: r = 36'sd652;
      5'd21: r = 36'sd326;
      5'd22: r = 36'sd163;
      5'd23: r = 36'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Item as it travels from the front to the back.
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] rate;
    logic signed [31:0] travel;    // forward_speed * time_step
    logic signed [15:0] full_turn; // heading step, rounded
    logic signed [15:0] half_turn; // midpoint offset, rounded
  } item_t;

  typedef struct packed {
    logic use_mid;
    logic load_x;
    logic load_y;
    logic load_h;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic [15:0]        val_h;
  } pose_ctl_t;

endpackage

>>> src/poi_front.sv
// ----------------------------------------------------------------------------
// poi_front: input stage
// Takes input transactions, forms distance and heading steps, feeds the queue.
// ----------------------------------------------------------------------------
module poi_front
  import poi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] in_data_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);

  // Stage 1 registers the products, stage 2 rounds the turn.
  logic               s1_q, s2_q;
  logic signed [15:0] spd_q, rate_q, spd2_q, rate2_q;
  logic signed [31:0] trav_q, wdt_q, trav2_q;
  logic signed [63:0] turn_q;
  logic signed [63:0] turn_full, turn_half;
  logic               take1, take2;

  assign take2 = s2_q & q_ready_i;
  assign take1 = s1_q & (~s2_q | take2);
  assign in_ready_o = ~s1_q | take1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_q <= in_valid_i;
      if (take1) s2_q <= 1'b1;
      else if (take2) s2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      spd_q  <= in_data_i[15:0];
      rate_q <= in_data_i[31:16];
      trav_q <= $signed(in_data_i[15:0]) * $signed({1'b0, in_data_i[47:32]});
      wdt_q  <= $signed(in_data_i[31:16]) * $signed({1'b0, in_data_i[47:32]});
    end
    if (take1) begin
      spd2_q  <= spd_q;
      rate2_q <= rate_q;
      trav2_q <= trav_q;
      turn_q  <= 64'(wdt_q) * TurnScale;
    end
  end

  assign turn_full = (turn_q + (64'sd1 <<< 43)) >>> 44;
  assign turn_half = (turn_q + (64'sd1 <<< 44)) >>> 45;
  assign q_item_o.speed     = spd2_q;
  assign q_item_o.rate      = rate2_q;
  assign q_item_o.travel    = trav2_q;
  assign q_item_o.full_turn = turn_full[15:0];
  assign q_item_o.half_turn = turn_half[15:0];
  assign q_valid_o = s2_q;

endmodule

>>> src/poi_fifo.sv
// ----------------------------------------------------------------------------
// poi_fifo: two-entry queue between front and back
// ----------------------------------------------------------------------------
module poi_fifo
  import poi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;
  assign rd_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

endmodule

>>> src/poi_back.sv
// ----------------------------------------------------------------------------
// poi_back: pose update engine
// Runs a shared rotation CORDIC twice per item, updates the pose, holds result.
// ----------------------------------------------------------------------------
module poi_back
  import poi_pkg::*;
#(
  parameter int unsigned TrigIter = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pose_ctl_t    ctl_i,
  input  logic         q_valid_i,
  output logic         q_ready_o,
  input  item_t        q_item_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [159:0] out_data_o,
  output logic         idle_o
);

  localparam int unsigned NIter = (TrigIter > MaxIter) ? MaxIter : TrigIter;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TRIG1 = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_ADD   = 7'b0001000,
    ST_TRIG2 = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e             state_q;
  logic [4:0]         it_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [1:0]         quad_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0]        ph_q;
  item_t              item_q;
  logic signed [47:0] mx_q, my_q;
  logic signed [15:0] c14, s14;
  logic signed [15:0] qc_q, qs_q;
  logic signed [35:0] rc, rs, sx, sy;
  logic               cdone;

  function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
    logic signed [36:0] r;
    r = (37'(v) + 37'sd32768) >>> 16;
    if (r > 37'sd16384) r = 37'sd16384;
    if (r < -37'sd16384) r = -37'sd16384;
    return r[15:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'h7fffffff;
    if (a < -64'sd2147483648) return 32'h80000000;
    return a[31:0];
  endfunction

  // Fold the angle to within one eighth turn of zero for the CORDIC.
  function automatic logic [1:0] quad_of(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h20000000;
    return t[31:30];
  endfunction

  function automatic logic [15:0] h_mid_of(input item_t it);
    return ph_q + (ctl_i.use_mid ? it.half_turn : 16'd0);
  endfunction

  function automatic logic [31:0] qfold(input logic [31:0] a);
    logic [1:0] q;
    q = quad_of(a);
    return a - {q, 30'd0};
  endfunction

  assign sx = cx_q >>> it_q;
  assign sy = cy_q >>> it_q;
  assign cdone = it_q == 5'(NIter - 1);

  always_comb begin
    case (quad_q)
      2'd0: begin rc = cx_q;  rs = cy_q;  end
      2'd1: begin rc = -cy_q; rs = cx_q;  end
      2'd2: begin rc = -cx_q; rs = -cy_q; end
      default: begin rc = cy_q; rs = -cx_q; end
    endcase
    c14 = to_q14(rc);
    s14 = to_q14(rs);
  end

  assign q_ready_o   = state_q == ST_IDLE && !ctl_i.load_x && !ctl_i.load_y
                       && !ctl_i.load_h;
  assign out_valid_o = state_q == ST_OUT;
  assign idle_o      = state_q == ST_IDLE;
  assign out_data_o  = {16'd0, item_q.rate, item_q.speed, qc_q, qs_q, ph_q, py_q, px_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      px_q <= '0;
      py_q <= '0;
      ph_q <= '0;
      it_q <= '0;
    end else begin
      if (ctl_i.load_x) px_q <= ctl_i.val_x;
      else if (state_q == ST_ADD)
        px_q <= sat(64'(px_q) + ((64'(mx_q) + (64'sd1 <<< 21)) >>> 22));
      if (ctl_i.load_y) py_q <= ctl_i.val_y;
      else if (state_q == ST_ADD)
        py_q <= sat(64'(py_q) + ((64'(my_q) + (64'sd1 <<< 21)) >>> 22));
      if (ctl_i.load_h) ph_q <= ctl_i.val_h;
      else if (state_q == ST_ADD) ph_q <= ph_q + item_q.full_turn;
      unique case (state_q)
        ST_IDLE: if (q_valid_i && q_ready_o) begin
          state_q <= ST_TRIG1;
          it_q <= '0;
        end
        ST_TRIG1: if (cdone) state_q <= ST_MUL; else it_q <= it_q + 5'd1;
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: begin
          state_q <= ST_TRIG2;
          it_q <= '0;
        end
        ST_TRIG2: if (cdone) state_q <= ST_FIN; else it_q <= it_q + 5'd1;
        ST_FIN: state_q <= ST_OUT;
        ST_OUT: if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i && q_ready_o) item_q <= q_item_i;
    // Load CORDIC at the start of each pass.
    if ((state_q == ST_IDLE && q_valid_i && q_ready_o) || state_q == ST_ADD) begin
      quad_q <= (state_q == ST_IDLE) ? quad_of({h_mid_of(q_item_i), 16'd0})
                                     : quad_of({1'b0, ph_q + item_q.full_turn, 15'd0});
      cz_q   <= (state_q == ST_IDLE)
                ? 36'($signed(qfold({h_mid_of(q_item_i), 16'd0})))
                : 36'($signed(qfold({1'b0, ph_q + item_q.full_turn, 15'd0})));
      cx_q   <= CordicGain;
      cy_q   <= '0;
    end else if (state_q == ST_TRIG1 || state_q == ST_TRIG2) begin
      if (!cz_q[35]) begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - atan_turn(it_q);
      end else begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + atan_turn(it_q);
      end
    end
    if (state_q == ST_MUL) begin
      mx_q <= item_q.travel * c14;
      my_q <= item_q.travel * s14;
    end
    if (state_q == ST_FIN) begin
      qc_q <= c14;
      qs_q <= s14;
    end
  end

endmodule

>>> src/planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator: dead-reckoning pose integrator
// ----------------------------------------------------------------------------
// Input stream s_axis: forward speed, turn rate and time step per transaction.
// Output stream m_axis: one transaction per input with new pose, yaw quaternion
// and the echoed velocities.
// Config channel cfg: index 0 selects midpoint integration, 1..3 load the start
// pose (and the live pose at once). Write only while the block is idle.
// The shared CORDIC runs two passes of TRIG_ITERATIONS steps (at most 24)
// per item; the back takes a new item only after the last result is accepted.
// At reset the pose and the midpoint setting are zero; the pipeline is empty.
// The front multiplies and rounds and can queue two items while the back works.
// A stalled receiver holds the result; the front keeps accepting until its
// queue fills.
// ----------------------------------------------------------------------------
module planar_odometry_integrator
  import poi_pkg::*;
#(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // forward_speed, turn_rate, time_step
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // pos_x, pos_y, heading, quat_z, quat_w,
                                       // speed_echo, rate_echo
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  item_t     f_item, b_item;
  logic      f_valid, f_ready, b_valid, b_ready, idle;
  logic      mid_q, cfg_wr;
  pose_ctl_t ctl;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (cfg_wr && cfg_index_i == REG_USE_MIDPOINT) begin
      mid_q <= cfg_data_i[0];
    end
  end

  always_comb begin
    ctl.use_mid = mid_q;
    ctl.load_x  = cfg_wr && cfg_index_i == REG_START_X;
    ctl.load_y  = cfg_wr && cfg_index_i == REG_START_Y;
    ctl.load_h  = cfg_wr && cfg_index_i == REG_START_HEADING;
    ctl.val_x   = cfg_data_i;
    ctl.val_y   = cfg_data_i;
    ctl.val_h   = cfg_data_i[15:0];
  end

  poi_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_item_o(f_item)
  );

  poi_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_item_o(b_item)
  );

  poi_back #(.TrigIter(TRIG_ITERATIONS)) u_back (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_item_i(b_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .idle_o(idle)
  );

  logic unused_idle;
  assign unused_idle = idle;

endmodule

>>> src/poi_checker.sv
// ----------------------------------------------------------------------------
// poi_checker: port-level checks for the odometry integrator
// ----------------------------------------------------------------------------
module poi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_quat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[95:80]) <= 16'sd16384 &&
      $signed(m_axis_tdata[95:80]) >= -16'sd16384 &&
      $signed(m_axis_tdata[111:96]) <= 16'sd16384 &&
      $signed(m_axis_tdata[111:96]) >= -16'sd16384)
    else $error("quaternion out of range");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[159:144] == 16'd0)
    else $error("pad bits set");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back-to-back results");

endmodule

bind planar_odometry_integrator poi_checker u_chk (.*);
